[sv/two_ring_bitcode_machine_core_assert.svh]
// Assertion macros used by the checker file trbm_checker.
`ifndef TWO_RING_BITCODE_MACHINE_CORE_ASSERT_SVH
`define TWO_RING_BITCODE_MACHINE_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset
`define TRBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define TRBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/trbm_pkg.sv]
`timescale 1ns / 1ps
package trbm_pkg;

    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int PROG_DEPTH_DEF = 4096;
    localparam int RING_SIZE      = 12;
    localparam int RING_LAST      = 11;
    localparam int LEN_W          = 13;
    localparam int PC_OUT_W       = 12;
    localparam int WORD_W         = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 56;

    // Operation ring positions
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_EXIT  = 4'd1;
    localparam logic [3:0] OP_ONE   = 4'd2;
    localparam logic [3:0] OP_ZERO  = 4'd3;
    localparam logic [3:0] OP_LOAD  = 4'd4;
    localparam logic [3:0] OP_STORE = 4'd5;
    localparam logic [3:0] OP_JUMP  = 4'd6;
    localparam logic [3:0] OP_MOVE  = 4'd7;
    localparam logic [3:0] OP_LOGIC = 4'd8;
    localparam logic [3:0] OP_JNZ   = 4'd9;
    localparam logic [3:0] OP_INTIO = 4'd10;
    localparam logic [3:0] OP_CHRIO = 4'd11;

    // Math ring positions
    localparam logic [3:0] MA_NONE  = 4'd0;
    localparam logic [3:0] MA_LOAD  = 4'd1;
    localparam logic [3:0] MA_STORE = 4'd2;
    localparam logic [3:0] MA_ADD   = 4'd3;
    localparam logic [3:0] MA_MUL   = 4'd4;
    localparam logic [3:0] MA_DIV   = 4'd5;
    localparam logic [3:0] MA_ZERO  = 4'd6;
    localparam logic [3:0] MA_LESS  = 4'd7;
    localparam logic [3:0] MA_GREAT = 4'd8;
    localparam logic [3:0] MA_EQUAL = 4'd9;
    localparam logic [3:0] MA_NOT   = 4'd10;
    localparam logic [3:0] MA_NEG   = 4'd11;

    // Run status codes
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_EXIT  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    // Output kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } md_rsp_t;

    // One result, packed as it leaves on tdata (next_pc lowest)
    typedef struct packed {
        logic                read_taken;
        logic [WORD_W-1:0]   out_value;
        logic [1:0]          out_kind;
        logic [1:0]          run_status;
        logic [PC_OUT_W-1:0] next_pc;
    } res_t;

    // Step a ring position one place in its direction
    function automatic logic [3:0] ring_turn(input logic dir, input logic [3:0] pos);
        logic [3:0] r;
        if (!dir)
            r = (pos >= 4'(RING_LAST)) ? 4'd0 : pos + 4'd1;
        else
            r = (pos == 4'd0 || pos > 4'(RING_LAST)) ? 4'(RING_LAST) : pos - 4'd1;
        return r;
    endfunction

endpackage

[sv/trbm_muldiv.sv]
`timescale 1ns / 1ps
module trbm_muldiv
    import trbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIX} md_state_t;

    md_state_t         state_reg, state_next;
    logic [WORD_W:0]   rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] res_reg, res_next;

    logic [WORD_W:0]   rem_sh;

    // One restoring divide step per cycle on magnitudes; the multiply product is registered before done
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_sh     = {rem_reg[WORD_W-1:0], quo_reg[WORD_W-1]};
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    if (req.is_div)
                    begin
                        rem_next   = '0;
                        quo_next   = req.a[WORD_W-1] ? (~req.a + 1'b1) : req.a;
                        dvs_next   = req.b[WORD_W-1] ? (~req.b + 1'b1) : req.b;
                        neg_next   = req.a[WORD_W-1] ^ req.b[WORD_W-1];
                        cnt_next   = '0;
                        state_next = M_DIV;
                    end
                    else
                    begin
                        res_next   = req.a * req.b;
                        state_next = M_MUL;
                    end
                end
            end
            M_MUL:
            begin
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            M_DIV:
            begin
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_next = rem_sh - {1'b0, dvs_reg};
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(WORD_W-1))
                    state_next = M_FIX;
            end
            M_FIX:
            begin
                res_next   = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

[sv/trbm_mem.sv]
`timescale 1ns / 1ps
module trbm_mem
    import trbm_pkg::*;
#(
    parameter int DEPTH = MEM_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata,
    output logic              busy
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     clr_idx_reg;
    logic              clearing_reg;

    // Sweep zeros through every cell after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == AW'(DEPTH - 1))
                clearing_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_idx_reg] <= '0;
        else if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

[sv/two_ring_bitcode_machine_core.sv]
`timescale 1ns / 1ps
// Channel       | Dir | Payload
// s_axis        | in  | tdata: instr_bit[0], read_value[32:1]
// m_axis        | out | tdata: next_pc[11:0], run_status[13:12], out_kind[15:14],
//               |     |        out_value[47:16], read_taken[48]
// cfg           | in  | cfg_wdata: program_length
// Each item is accepted in S_IDLE with the cell read issued, then executed in
// S_EXEC with the registered cell data. Multiply and divide then wait in S_WAIT
// for the shared multiply/divide unit. After reset the data memory is zeroed one
// cell per cycle with s_axis_tready low. A result waits in the output register
// while m_axis is stalled; a second finished result is held until that register
// frees, and no new item is accepted meanwhile.
module two_ring_bitcode_machine_core
    import trbm_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = PROG_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // instr_bit, read_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // next_pc, run_status, out_kind,
                                                  // out_value, read_taken
    input  logic                   cfg_wen,
    input  logic [LEN_W-1:0]       cfg_wdata
);

    localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PCW = $clog2(PROG_DEPTH + 1);
    localparam int LW  = (PCW > LEN_W) ? PCW : LEN_W;
    localparam int SW  = WORD_W + 2;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_WAIT, S_DONE} state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              op_dir_reg, op_dir_next;
    logic [3:0]        op_pos_reg, op_pos_next;
    logic [WORD_W-1:0] op_val_reg, op_val_next;
    logic              m_dir_reg, m_dir_next;
    logic [3:0]        m_pos_reg, m_pos_next;
    logic [WORD_W-1:0] m_val_reg, m_val_next;
    logic              on_math_reg, on_math_next;
    logic              armed_reg, armed_next;
    logic [PCW-1:0]    pc_reg, pc_next;
    logic [AW-1:0]     dp_reg, dp_next;
    logic              halted_reg, halted_next;
    logic [1:0]        stop_reg, stop_next;
    logic              bit_reg, bit_next;
    logic [WORD_W-1:0] rv_reg, rv_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    res_t              pend_reg, pend_next;

    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] cell_data;
    logic              mem_busy;
    md_req_t           md_req;
    md_rsp_t           md_rsp;

    logic [LW-1:0]     eff_len;
    logic [SW-1:0]     t_sum;
    logic [SW-1:0]     t_bound;
    logic              t_bad;
    logic [PCW-1:0]    pc_inc;
    logic              slot_free;
    logic              fin;
    logic              go_wait;
    logic              jumped;
    logic [1:0]        code;
    res_t              res;

    trbm_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (dp_reg),
        .wdata (mem_wdata),
        .raddr (dp_reg),
        .rdata (cell_data),
        .busy  (mem_busy)
    );

    trbm_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Length in use, limited to the program depth
    assign eff_len = (LW'(len_reg) > LW'(PROG_DEPTH)) ? LW'(PROG_DEPTH) : LW'(len_reg);

    // Shared target adder for jumps and data pointer moves
    assign t_sum   = SW'((op_pos_reg == OP_MOVE) ? LW'(dp_reg) : LW'(pc_reg))
                   + {{(SW-WORD_W){op_val_reg[WORD_W-1]}}, op_val_reg};
    assign t_bound = (op_pos_reg == OP_MOVE) ? SW'(MEM_DEPTH) : SW'(eff_len);
    assign t_bad   = t_sum[SW-1] || (t_sum >= t_bound);

    assign pc_inc    = pc_reg + 1'b1;
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = cfg_wen ? cfg_wdata : len_reg;
        op_dir_next    = op_dir_reg;
        op_pos_next    = op_pos_reg;
        op_val_next    = op_val_reg;
        m_dir_next     = m_dir_reg;
        m_pos_next     = m_pos_reg;
        m_val_next     = m_val_reg;
        on_math_next   = on_math_reg;
        armed_next     = armed_reg;
        pc_next        = pc_reg;
        dp_next        = dp_reg;
        halted_next    = halted_reg;
        stop_next      = stop_reg;
        bit_next       = bit_reg;
        rv_next        = rv_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        md_req         = '0;
        fin            = 1'b0;
        go_wait        = 1'b0;
        jumped         = 1'b0;
        code           = ST_RUN;
        res            = '0;
        s_axis_tready  = (state_reg == S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                if (!mem_busy)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // Latch the item; the cell read is under way
                if (s_axis_tvalid)
                begin
                    bit_next   = s_axis_tdata[0];
                    rv_next    = s_axis_tdata[WORD_W:1];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!halted_reg)
                begin
                    if (LW'(pc_reg) >= eff_len)
                    begin
                        halted_next = 1'b1;
                        stop_next   = ST_END;
                    end
                    else
                    begin
                        if (bit_reg)
                        begin
                            // Rotate the current ring
                            if (on_math_reg)
                                m_pos_next = ring_turn(m_dir_reg, m_pos_reg);
                            else
                                op_pos_next = ring_turn(op_dir_reg, op_pos_reg);
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            // Reverse, then execute on a second zero
                            if (on_math_reg)
                                m_dir_next = !m_dir_reg;
                            else
                                op_dir_next = !op_dir_reg;
                            if (armed_reg)
                            begin
                                armed_next = 1'b0;
                                if (on_math_reg)
                                begin
                                    case (m_pos_reg)
                                        MA_NONE:  ;
                                        MA_LOAD:  m_val_next = cell_data;
                                        MA_STORE:
                                        begin
                                            mem_we    = 1'b1;
                                            mem_wdata = m_val_reg;
                                        end
                                        MA_ADD:   m_val_next = m_val_reg + cell_data;
                                        MA_MUL:   go_wait = 1'b1;
                                        MA_DIV:
                                        begin
                                            if (cell_data == '0)
                                                code = ST_FAULT;
                                            else
                                                go_wait = 1'b1;
                                        end
                                        MA_ZERO:  m_val_next = '0;
                                        MA_LESS:
                                            m_val_next = WORD_W'($signed(m_val_reg) <
                                                                 $signed(cell_data));
                                        MA_GREAT:
                                            m_val_next = WORD_W'($signed(m_val_reg) >
                                                                 $signed(cell_data));
                                        MA_EQUAL: m_val_next = WORD_W'(m_val_reg == cell_data);
                                        MA_NOT:   m_val_next = WORD_W'(m_val_reg == '0);
                                        MA_NEG:   m_val_next = '0 - m_val_reg;
                                        default:  code = ST_FAULT;
                                    endcase
                                end
                                else
                                begin
                                    case (op_pos_reg)
                                        OP_NONE:  ;
                                        OP_ONE:   op_val_next = WORD_W'(1);
                                        OP_ZERO:  op_val_next = '0;
                                        OP_LOAD:  op_val_next = cell_data;
                                        OP_STORE:
                                        begin
                                            mem_we    = 1'b1;
                                            mem_wdata = op_val_reg;
                                        end
                                        OP_JUMP:
                                        begin
                                            if (t_bad)
                                                code = ST_FAULT;
                                            else
                                            begin
                                                pc_next = t_sum[PCW-1:0];
                                                jumped  = 1'b1;
                                            end
                                        end
                                        OP_MOVE:
                                        begin
                                            if (t_bad)
                                                code = ST_FAULT;
                                            else
                                                dp_next = t_sum[AW-1:0];
                                        end
                                        OP_LOGIC:
                                            op_val_next = WORD_W'(cell_data != '0 &&
                                                                  op_val_reg != '0);
                                        OP_JNZ:
                                        begin
                                            if (cell_data != '0)
                                            begin
                                                if (t_bad)
                                                    code = ST_FAULT;
                                                else
                                                begin
                                                    pc_next = t_sum[PCW-1:0];
                                                    jumped  = 1'b1;
                                                end
                                            end
                                        end
                                        OP_INTIO, OP_CHRIO:
                                        begin
                                            if (op_val_reg == '0)
                                            begin
                                                mem_we         = 1'b1;
                                                mem_wdata      = rv_reg;
                                                res.read_taken = 1'b1;
                                            end
                                            else
                                            begin
                                                res.out_kind  = (op_pos_reg == OP_INTIO) ?
                                                                KIND_INT : KIND_CHAR;
                                                res.out_value = cell_data;
                                            end
                                        end
                                        default:  code = ST_EXIT;
                                    endcase
                                end
                                if (code != ST_RUN)
                                begin
                                    halted_next = 1'b1;
                                    stop_next   = code;
                                end
                                else if (!go_wait)
                                    on_math_next = !on_math_reg;
                            end
                            else
                                armed_next = 1'b1;
                        end
                        // Advance the counter unless a jump, a stop or the unit intervenes
                        if (code == ST_RUN && !jumped && !go_wait)
                        begin
                            pc_next = pc_inc;
                            if (LW'(pc_inc) >= eff_len)
                            begin
                                halted_next = 1'b1;
                                stop_next   = ST_END;
                            end
                        end
                    end
                end
                if (go_wait)
                begin
                    md_req.start  = 1'b1;
                    md_req.is_div = (m_pos_reg == MA_DIV);
                    md_req.a      = m_val_reg;
                    md_req.b      = cell_data;
                    state_next    = S_WAIT;
                end
                else
                    fin = 1'b1;
            end
            S_WAIT:
            begin
                // Retire the multiply or divide
                if (md_rsp.done)
                begin
                    m_val_next   = md_rsp.result;
                    on_math_next = !on_math_reg;
                    pc_next      = pc_inc;
                    if (LW'(pc_inc) >= eff_len)
                    begin
                        halted_next = 1'b1;
                        stop_next   = ST_END;
                    end
                    fin = 1'b1;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Hand the finished result to the output register, or hold it
        if (fin)
        begin
            res.next_pc    = PC_OUT_W'(pc_next);
            res.run_status = halted_next ? stop_next : ST_RUN;
            if (slot_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_reg       <= LEN_W'(1);
            op_dir_reg    <= 1'b0;
            op_pos_reg    <= '0;
            op_val_reg    <= '0;
            m_dir_reg     <= 1'b0;
            m_pos_reg     <= '0;
            m_val_reg     <= '0;
            on_math_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            pc_reg        <= '0;
            dp_reg        <= '0;
            halted_reg    <= 1'b0;
            stop_reg      <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            op_dir_reg    <= op_dir_next;
            op_pos_reg    <= op_pos_next;
            op_val_reg    <= op_val_next;
            m_dir_reg     <= m_dir_next;
            m_pos_reg     <= m_pos_next;
            m_val_reg     <= m_val_next;
            on_math_reg   <= on_math_next;
            armed_reg     <= armed_next;
            pc_reg        <= pc_next;
            dp_reg        <= dp_next;
            halted_reg    <= halted_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        rv_reg   <= rv_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, out_reg};

endmodule

[sv/trbm_checker.sv]
`timescale 1ns / 1ps
`include "two_ring_bitcode_machine_core_assert.svh"
module trbm_checker
    import trbm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result
    `TRBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // Drop ready while an accepted transaction is worked on
    `TRBM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")

    // Never print and read in one step
    `TRBM_ASSERT_NOW(a_print_xor_read, m_axis_tvalid && m_axis_tdata[48], m_axis_tdata[15:14] == KIND_NONE, "print and read together")

    // Zero value when nothing prints
    `TRBM_ASSERT_NOW(a_quiet_zero, m_axis_tvalid && m_axis_tdata[15:14] == KIND_NONE, m_axis_tdata[47:16] == '0, "value without output")

endmodule

bind two_ring_bitcode_machine_core trbm_checker u_trbm_checker (.*);

[dv/two_ring_bitcode_machine_core_checker.sv]
`timescale 1ns / 1ps
module two_ring_bitcode_machine_core_checker
    import trbm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // instr_bit, read_value
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // next_pc, run_status, out_kind,
                                                   // out_value, read_taken
    input  logic                   cfg_wen,
    input  logic [LEN_W-1:0]       cfg_wdata,
    output int                     fail_count,
    output int                     results_pending
);

    localparam int MEM_WORDS  = MEM_DEPTH_DEF;
    localparam int PROG_WORDS = PROG_DEPTH_DEF;

    // Shadow machine state
    logic [LEN_W-1:0] prog_len;
    logic             op_dir;
    logic             math_dir;
    logic [3:0]       op_pos;
    logic [3:0]       math_pos;
    logic [31:0]      op_val;
    logic [31:0]      math_val;
    logic             on_math;
    logic             armed;
    logic             stopped;
    logic [1:0]       stop_st;
    logic [31:0]      pc;
    logic [31:0]      dptr;
    logic [31:0]      cells [MEM_WORDS];

    res_t expected_results[$];
    int   mismatches;

    function automatic logic [3:0] step_pos(input logic dir, input logic [3:0] pos);
        if (!dir)
            return (pos >= 4'(RING_LAST)) ? 4'd0 : pos + 4'd1;
        return (pos == 4'd0 || pos > 4'(RING_LAST)) ? 4'(RING_LAST) : pos - 4'd1;
    endfunction

    function automatic longint len_in_use();
        return (prog_len > PROG_WORDS) ? longint'(PROG_WORDS) : longint'(prog_len);
    endfunction

    function automatic longint sext(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // Relative jump; out of range faults
    task automatic branch(input logic [31:0] v, inout logic [1:0] code, inout bit jumped);
        longint t;
        t = longint'(pc) + sext(v);
        if (t < 0 || t >= len_in_use())
            code = ST_FAULT;
        else
        begin
            pc = 32'(t);
            jumped = 1'b1;
        end
    endtask

    // Advance the shadow machine by one program bit
    task automatic predict(input logic bit_in, input logic [31:0] rv, output res_t r);
        logic [1:0]  code;
        logic [1:0]  kind;
        logic [31:0] outv;
        logic [31:0] c;
        logic [31:0] v;
        logic        taken;
        bit          jumped;
        longint      t;
        longint      a;
        longint      b;
        code   = ST_RUN;
        kind   = KIND_NONE;
        outv   = '0;
        taken  = 1'b0;
        jumped = 1'b0;
        if (!stopped && longint'(pc) >= len_in_use())
        begin
            stopped = 1'b1;
            stop_st = ST_END;
        end
        if (!stopped)
        begin
            if (bit_in)
            begin
                if (on_math)
                    math_pos = step_pos(math_dir, math_pos);
                else
                    op_pos = step_pos(op_dir, op_pos);
                armed = 1'b0;
            end
            else
            begin
                if (on_math)
                    math_dir = !math_dir;
                else
                    op_dir = !op_dir;
                if (armed)
                begin
                    armed = 1'b0;
                    c = (dptr < MEM_WORDS) ? cells[dptr] : '0;
                    if (on_math)
                    begin
                        v = math_val;
                        a = sext(v);
                        b = sext(c);
                        case (math_pos)
                            MA_NONE:  ;
                            MA_LOAD:  v = c;
                            MA_STORE: cells[dptr] = v;
                            MA_ADD:   v = v + c;
                            MA_MUL:   v = v * c;
                            MA_DIV:
                            begin
                                if (c == '0)
                                    code = ST_FAULT;
                                else
                                    v = 32'(a / b);
                            end
                            MA_ZERO:  v = '0;
                            MA_LESS:  v = (a < b) ? 32'd1 : 32'd0;
                            MA_GREAT: v = (a > b) ? 32'd1 : 32'd0;
                            MA_EQUAL: v = (v == c) ? 32'd1 : 32'd0;
                            MA_NOT:   v = (v != '0) ? 32'd0 : 32'd1;
                            MA_NEG:   v = 32'd0 - v;
                            default:  code = ST_FAULT;
                        endcase
                        if (code == ST_RUN)
                            math_val = v;
                    end
                    else
                    begin
                        case (op_pos)
                            OP_NONE:  ;
                            OP_ONE:   op_val = 32'd1;
                            OP_ZERO:  op_val = 32'd0;
                            OP_LOAD:  op_val = c;
                            OP_STORE: cells[dptr] = op_val;
                            OP_JUMP:  branch(op_val, code, jumped);
                            OP_MOVE:
                            begin
                                t = longint'(dptr) + sext(op_val);
                                if (t < 0 || t >= MEM_WORDS)
                                    code = ST_FAULT;
                                else
                                    dptr = 32'(t);
                            end
                            OP_LOGIC: op_val = (c != '0 && op_val != '0) ? 32'd1 : 32'd0;
                            OP_JNZ:
                            begin
                                if (c != '0)
                                    branch(op_val, code, jumped);
                            end
                            OP_INTIO, OP_CHRIO:
                            begin
                                if (op_val == '0)
                                begin
                                    cells[dptr] = rv;
                                    taken = 1'b1;
                                end
                                else
                                begin
                                    kind = (op_pos == OP_INTIO) ? KIND_INT : KIND_CHAR;
                                    outv = c;
                                end
                            end
                            default:  code = ST_EXIT;
                        endcase
                    end
                    // A stopping op leaves the current ring in place
                    if (code != ST_RUN)
                    begin
                        stopped = 1'b1;
                        stop_st = code;
                    end
                    else
                        on_math = !on_math;
                end
                else
                    armed = 1'b1;
            end
            if (!stopped && !jumped)
            begin
                pc = pc + 32'd1;
                if (longint'(pc) >= len_in_use())
                begin
                    stopped = 1'b1;
                    stop_st = ST_END;
                end
            end
        end
        r.next_pc    = pc[PC_OUT_W-1:0];
        r.run_status = stopped ? stop_st : ST_RUN;
        r.out_kind   = kind;
        r.out_value  = outv;
        r.read_taken = taken;
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, field, exp_v, got_v);
    endtask

    // Track inputs, predict, and compare each output transaction
    always @(posedge clk or negedge rst_n)
    begin : track
        res_t exp_r;
        res_t got_r;
        if (!rst_n)
        begin
            prog_len = LEN_W'(1);
            op_dir   = 1'b0;
            math_dir = 1'b0;
            op_pos   = '0;
            math_pos = '0;
            op_val   = '0;
            math_val = '0;
            on_math  = 1'b0;
            armed    = 1'b0;
            stopped  = 1'b0;
            stop_st  = ST_RUN;
            pc       = '0;
            dptr     = '0;
            for (int i = 0; i < MEM_WORDS; i++)
                cells[i] = '0;
            expected_results.delete();
            mismatches = 0;
            fail_count      <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_wen)
                prog_len = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict(s_axis_tdata[0], s_axis_tdata[32:1], exp_r);
                expected_results = {expected_results, exp_r};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with nothing expected: 0x%h",
                                 $realtime, got_r);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.next_pc != exp_r.next_pc)
                        note_mismatch("next_pc", 32'(exp_r.next_pc), 32'(got_r.next_pc));
                    if (got_r.run_status != exp_r.run_status)
                        note_mismatch("run_status", 32'(exp_r.run_status),
                                      32'(got_r.run_status));
                    if (got_r.out_kind != exp_r.out_kind)
                        note_mismatch("out_kind", 32'(exp_r.out_kind), 32'(got_r.out_kind));
                    if (got_r.out_value != exp_r.out_value)
                        note_mismatch("out_value", exp_r.out_value, got_r.out_value);
                    if (got_r.read_taken != exp_r.read_taken)
                        note_mismatch("read_taken", 32'(exp_r.read_taken),
                                      32'(got_r.read_taken));
                end
            end
            fail_count      <= mismatches;
            results_pending <= expected_results.size();
        end
    end

endmodule

[dv/two_ring_bitcode_machine_core_test.sv]
`timescale 1ns / 1ps
module two_ring_bitcode_machine_core_test;
    import trbm_pkg::*;

    localparam int STUCK_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 570;

    typedef enum int {VAL_ZERO, VAL_ONE, VAL_BIT, VAL_ANY} op_val_t;
    typedef enum int {STOP_EXIT, STOP_DIV0, STOP_JUMP_OUT, STOP_SHRINK} stop_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // instr_bit, read_value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // next_pc, run_status, out_kind,
                                                 // out_value, read_taken
    logic                   cfg_wen = 1'b0;
    logic [LEN_W-1:0]       cfg_wdata = '0;

    int  chk_fail;
    int  chk_pending;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_left = 0;
    logic hold_go = 1'b0;
    int  stuck = 0;
    int  results_seen = 0;
    logic [PC_OUT_W-1:0] last_pc = '0;

    // Ring and data tracking used to keep programs running
    logic       odir_t = 1'b0;
    logic       mdir_t = 1'b0;
    logic [3:0] opos_t = '0;
    logic [3:0] mpos_t = '0;
    logic       on_math_t = 1'b0;
    op_val_t    val_st = VAL_ZERO;
    int         dp_t = 0;
    bit         cell_nz = 1'b0;
    int         bits_sent = 0;

    two_ring_bitcode_machine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    two_ring_bitcode_machine_core_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (chk_fail),
        .results_pending (chk_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output backpressure, with a long hold on request
    always @(posedge clk)
    begin
        if (hold_go && hold_left == 0)
        begin
            hold_left     <= HOLD_CYCLES;
            hold_go       <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on transactions, and last reported program index
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (m_axis_tvalid && m_axis_tready)
        begin
            last_pc      <= m_axis_tdata[PC_OUT_W-1:0];
            results_seen <= results_seen + 1;
        end
        if (stuck >= STUCK_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            4:       return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int steps_to(input logic dir, input logic [3:0] pos,
                                    input logic [3:0] target);
        if (!dir)
            return (int'(target) - int'(pos) + RING_SIZE) % RING_SIZE;
        return (int'(pos) - int'(target) + RING_SIZE) % RING_SIZE;
    endfunction

    // Offer one program bit, with random idle cycles ahead of it
    task automatic send(input logic b, input logic [31:0] rv);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, rv, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        bits_sent++;
    endtask

    // Hold input until every result is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_len(input int len);
        cfg_wen   <= 1'b1;
        cfg_wdata <= LEN_W'(len);
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Turn the current ring to an op, run it, and update tracking
    task automatic run_op(input logic [3:0] code, input logic [31:0] rv, input bit allow_flip);
        logic dir;
        logic [3:0] pos;
        int k;
        dir = on_math_t ? mdir_t : odir_t;
        pos = on_math_t ? mpos_t : opos_t;
        if (allow_flip && $urandom_range(0, 1) == 1 && steps_to(!dir, pos, code) != 0)
        begin
            send(1'b0, $urandom);
            dir = !dir;
        end
        k = steps_to(dir, pos, code);
        repeat (k) send(1'b1, $urandom);
        send(1'b0, $urandom);
        send(1'b0, rv);
        if (on_math_t)
        begin
            mdir_t = dir;
            mpos_t = code;
            if (code == MA_STORE)
                cell_nz = 1'b0;
        end
        else
        begin
            odir_t = dir;
            opos_t = code;
            case (code)
                OP_ONE:   val_st = VAL_ONE;
                OP_ZERO:  val_st = VAL_ZERO;
                OP_LOAD:  val_st = VAL_ANY;
                OP_LOGIC: val_st = VAL_BIT;
                OP_STORE: cell_nz = (val_st == VAL_ONE);
                OP_MOVE:
                begin
                    if (val_st == VAL_ONE)
                        dp_t++;
                    cell_nz = 1'b0;
                end
                OP_INTIO, OP_CHRIO:
                begin
                    if (val_st == VAL_ZERO)
                        cell_nz = (rv != '0);
                    else if (val_st != VAL_ONE)
                        cell_nz = 1'b0;
                end
                default: ;
            endcase
        end
        on_math_t = !on_math_t;
    endtask

    // One op on the current ring, steered away from anything that halts
    task automatic random_op();
        logic [3:0] code;
        int r;
        r = $urandom_range(0, 15);
        if (!on_math_t)
        begin
            if (r >= 12)
                code = (r == 12) ? OP_ZERO : ((r == 13) ? OP_INTIO : OP_CHRIO);
            else
                code = 4'(r);
            if (code == OP_EXIT)
                code = OP_NONE;
            if ((code == OP_JUMP || code == OP_JNZ) && val_st == VAL_ANY)
                code = OP_ZERO;
            if (code == OP_MOVE && !((val_st == VAL_ZERO || val_st == VAL_ONE)
                                     && dp_t < MEM_DEPTH_DEF - 1))
                code = OP_ONE;
        end
        else
        begin
            code = (r >= 12) ? MA_DIV : 4'(r);
            if (code == MA_DIV && !cell_nz)
                code = MA_ADD;
        end
        run_op(code, pick_value(), 1'b1);
    endtask

    initial
    begin : stimulus
        stop_t how;
        int    target;
        int    n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_len(PROG_DEPTH_DEF);

        // Directed: reads of extreme values, most negative by minus one, print
        run_op(OP_ZERO, '0, 1'b0);
        run_op(MA_ZERO, '0, 1'b1);
        run_op(OP_INTIO, 32'h8000_0000, 1'b0);
        run_op(MA_LOAD, '0, 1'b0);
        run_op(OP_CHRIO, 32'hFFFF_FFFF, 1'b1);
        run_op(MA_DIV, '0, 1'b0);
        run_op(OP_ONE, '0, 1'b0);
        run_op(MA_NEG, '0, 1'b0);
        run_op(OP_INTIO, '0, 1'b0);

        // Random programs under three idle patterns, with a shortened length in the second
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 17 : ((ph == 1) ? 78 : 0);
            recv_idle_pct = (ph == 0) ? 78 : ((ph == 1) ? 17 : 0);
            if (ph > 0)
            begin
                drain();
                write_len((ph == 1) ? $urandom_range(2600, PROG_DEPTH_DEF - 1)
                                    : PROG_DEPTH_DEF);
            end
            else
                hold_go <= 1'b1;
            target = bits_sent + PHASE_ITEMS;
            while (bits_sent < target)
                random_op();
        end

        // Stop the run one way, then check that the halt holds
        drain();
        how = stop_t'($urandom_range(0, 3));
        if (how != STOP_SHRINK && on_math_t)
            run_op(MA_NONE, '0, 1'b1);
        case (how)
            STOP_EXIT:
                run_op(OP_EXIT, '0, 1'b1);
            STOP_DIV0:
            begin
                run_op(OP_ZERO, '0, 1'b1);
                run_op(MA_NONE, '0, 1'b1);
                run_op(OP_STORE, '0, 1'b1);
                run_op(MA_DIV, '0, 1'b1);
            end
            STOP_JUMP_OUT:
            begin
                run_op(OP_ONE, '0, 1'b1);
                run_op(MA_NONE, '0, 1'b1);
                drain();
                n = steps_to(odir_t, opos_t, OP_JUMP) + 2;
                write_len(int'(last_pc) + n);
                run_op(OP_JUMP, '0, 1'b0);
            end
            default:
                write_len(1);
        endcase
        repeat (20) send(1'($urandom), $urandom);
        drain();
        write_len(1);
        repeat (5) send(1'($urandom), $urandom);
        drain();

        $display("Ran %0d program bits, %0d results checked, three idle patterns and a long hold",
                 bits_sent, results_seen);
        $display("Run stopped by %s, then frozen state checked", how.name());
        if (chk_fail == 0 && chk_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
